[hw/rtl/tick_slot_input_collector_top_macros.svh]
// Assertion macros for the tick slot input collector.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TICK_SLOT_INPUT_COLLECTOR_TOP_MACROS_SVH
`define TICK_SLOT_INPUT_COLLECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TSIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tsic_pkg.sv]
// Shared types and constants of the tick slot input collector.
// No dependencies; used by every module of the block but tsic_fifo.
`timescale 1ns / 1ps

package tsic_pkg;

  localparam int unsigned QUEUE_TICKS_DEF  = 16;
  localparam int unsigned PLAYER_LIMIT_DEF = 8;
  localparam int unsigned PAYLOAD_BITS     = 32;
  localparam int unsigned TICK_W           = 64;
  localparam int unsigned PLAYER_W         = 3;
  localparam int unsigned CFG_W            = 4;

  // Command codes
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_TAKE   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_AHEAD     = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_NOT_READY = 3'd5,
    ST_TAKEN     = 3'd6
  } status_e;

  // Input word
  typedef struct packed {
    logic                    command;
    logic [PLAYER_W-1:0]     player_id;
    logic [TICK_W-1:0]       tick_number;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_t;

  // Result word
  typedef struct packed {
    status_e                 status;
    logic [TICK_W-1:0]       out_tick;
    logic [PLAYER_W-1:0]     out_player;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    last;
  } res_t;

  // Classified command, queued from front to back
  typedef struct packed {
    logic                    take;
    logic                    unknown;
    logic [PLAYER_W-1:0]     player;
    logic [TICK_W-1:0]       tick;
    logic [PAYLOAD_BITS-1:0] payload;
  } cmd_t;

endpackage

[hw/rtl/tsic_fifo.sv]
// Small register queue used between front and back and on the result side.
// No package dependency.
`timescale 1ns / 1ps

module tsic_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/tsic_front.sv]
// Front end: accepts input words, flags unknown players, queues commands.
// Depends on tsic_pkg and tsic_fifo.
`timescale 1ns / 1ps

module tsic_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  tsic_pkg::in_t                  item_i,
  input  logic [tsic_pkg::CFG_W-1:0]     n_players_i,
  output logic                           q_valid_o,
  input  logic                           q_pop_i,
  output tsic_pkg::cmd_t                 q_data_o
);

  tsic_pkg::cmd_t cmd_in;
  logic           q_empty;

  // Classify the incoming word
  always_comb begin
    cmd_in.take    = (item_i.command == tsic_pkg::CMD_TAKE);
    cmd_in.unknown = (item_i.command == tsic_pkg::CMD_SUBMIT) &&
                     ({1'b0, item_i.player_id} >= n_players_i);
    cmd_in.player  = item_i.player_id;
    cmd_in.tick    = item_i.tick_number;
    cmd_in.payload = item_i.payload;
  end

  // Command queue toward the back end
  tsic_fifo #(
    .WIDTH ($bits(tsic_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .rd_i    (q_pop_i),
    .empty_o (q_empty),
    .data_o  (q_data_o)
  );

  assign q_valid_o = !q_empty;

endmodule

[hw/rtl/tsic_back.sv]
// Back end: window check, slot bookkeeping, payload store and take sequencing.
// Depends on tsic_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tick_slot_input_collector_top_macros.svh"

module tsic_back #(
  parameter int unsigned QUEUE_TICKS  = tsic_pkg::QUEUE_TICKS_DEF,
  parameter int unsigned PLAYER_LIMIT = tsic_pkg::PLAYER_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tsic_pkg::CFG_W-1:0] n_players_i,
  input  logic                       q_valid_i,
  input  tsic_pkg::cmd_t             q_data_i,
  output logic                       q_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tsic_pkg::res_t             res_o
);

  localparam int unsigned SLOT_W    = $clog2(QUEUE_TICKS);
  localparam int unsigned SUM_W     = SLOT_W + 1;
  localparam int unsigned PAY_DEPTH = QUEUE_TICKS * PLAYER_LIMIT;
  localparam int unsigned PAY_AW    = $clog2(PAY_DEPTH);
  localparam int unsigned TICK_W    = tsic_pkg::TICK_W;
  localparam int unsigned PLAYER_W  = tsic_pkg::PLAYER_W;
  localparam int unsigned CFG_W     = tsic_pkg::CFG_W;
  localparam int unsigned PAY_W     = tsic_pkg::PAYLOAD_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_READ   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_RESP   = 7'b0010000,
    S_FETCH  = 7'b0100000,
    S_TAKE   = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  tsic_pkg::cmd_t          cur_q;
  logic [TICK_W-1:0]       tick_q;
  logic [TICK_W:0]         diff_q;
  tsic_pkg::status_e       status_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [PLAYER_W-1:0]     pidx_q;
  logic [TICK_W-1:0]       next_tick_q;
  logic [SLOT_W-1:0]       next_slot_q;
  logic [QUEUE_TICKS-1:0]  slot_valid_q;

  logic [PLAYER_LIMIT-1:0] rcv_mem [QUEUE_TICKS];
  logic [PLAYER_LIMIT-1:0] rcv_rd_q;
  logic                    rcv_vld_q;
  logic [PAY_W-1:0]        pay_mem [PAY_DEPTH];
  logic [PAY_W-1:0]        pay_rd_q;

  tsic_pkg::status_e       cls_status;
  logic                    cls_err;
  logic [SUM_W-1:0]        slot_sum;
  logic [SLOT_W-1:0]       slot_nx;
  logic [PLAYER_LIMIT-1:0] rcv_cur, pbit, complete;
  logic                    dup, take_ok, take_last;
  logic [SLOT_W-1:0]       next_slot_inc;

  function automatic logic [PAY_AW-1:0] pay_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [PLAYER_W-1:0] player);
    return PAY_AW'(32'(slot) * PLAYER_LIMIT + 32'(player));
  endfunction

  // Window classification and slot of the submitted tick
  always_comb begin
    slot_sum = {1'b0, next_slot_q} + {1'b0, diff_q[SLOT_W-1:0]};
    if (slot_sum >= SUM_W'(QUEUE_TICKS)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_TICKS);
    end
    cls_err    = 1'b1;
    cls_status = tsic_pkg::ST_ACCEPTED;
    if (cur_q.take) begin
      cls_err = 1'b0;
    end else if (cur_q.unknown) begin
      cls_status = tsic_pkg::ST_UNKNOWN;
    end else if (diff_q[TICK_W]) begin
      cls_status = tsic_pkg::ST_ALREADY;
    end else if (diff_q[TICK_W-1:0] >= TICK_W'(QUEUE_TICKS)) begin
      cls_status = tsic_pkg::ST_AHEAD;
    end else begin
      cls_err = 1'b0;
    end
    slot_nx = cur_q.take ? next_slot_q : slot_sum[SLOT_W-1:0];
  end

  // Received mask checks
  always_comb begin
    for (int i = 0; i < PLAYER_LIMIT; i++) begin
      pbit[i]     = (cur_q.player == PLAYER_W'(i));
      complete[i] = (CFG_W'(i) < n_players_i);
    end
    rcv_cur   = rcv_vld_q ? rcv_rd_q : '0;
    dup       = |(rcv_cur & pbit);
    take_ok   = (rcv_cur == complete);
    take_last = (({1'b0, pidx_q} + CFG_W'(1)) == n_players_i);
    next_slot_inc = (next_slot_q == SLOT_W'(QUEUE_TICKS - 1)) ?
                    '0 : next_slot_q + SLOT_W'(1);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (q_valid_i) state_d = S_CHECK;
      S_CHECK:  state_d = S_READ;
      S_READ:   state_d = cls_err ? S_RESP : S_DECIDE;
      S_DECIDE: state_d = (cur_q.take && take_ok) ? S_FETCH : S_RESP;
      S_RESP:   if (res_ready_i) state_d = S_IDLE;
      S_FETCH:  state_d = S_TAKE;
      S_TAKE:   if (res_ready_i) state_d = take_last ? S_IDLE : S_FETCH;
      default:  state_d = S_IDLE;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_tick_q  <= '0;
      next_slot_q  <= '0;
      slot_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DECIDE) begin
        if (cur_q.take && take_ok) begin
          slot_valid_q[slot_q] <= 1'b0;
          next_tick_q          <= next_tick_q + TICK_W'(1);
          next_slot_q          <= next_slot_inc;
        end else if (!cur_q.take && !dup) begin
          slot_valid_q[slot_q] <= 1'b1;
        end
      end
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) cur_q <= q_data_i;
      end
      S_CHECK: begin
        tick_q <= cur_q.take ? next_tick_q : cur_q.tick;
        diff_q <= {1'b0, cur_q.tick} - {1'b0, next_tick_q};
      end
      S_READ: begin
        status_q <= cls_status;
        slot_q   <= slot_nx;
      end
      S_DECIDE: begin
        pidx_q <= '0;
        if (cur_q.take) begin
          status_q <= tsic_pkg::ST_NOT_READY;
        end else begin
          status_q <= dup ? tsic_pkg::ST_DUPLICATE : tsic_pkg::ST_ACCEPTED;
        end
      end
      S_TAKE: begin
        if (res_ready_i) pidx_q <= pidx_q + PLAYER_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Received mask store: read at the classified slot, updated on accept
  always_ff @(posedge clk_i) begin
    rcv_rd_q  <= rcv_mem[slot_nx];
    rcv_vld_q <= slot_valid_q[slot_nx];
    if ((state_q == S_DECIDE) && !cur_q.take && !dup) begin
      rcv_mem[slot_q] <= rcv_cur | pbit;
    end
  end

  // Payload store: written on accept, read once per emitted player
  always_ff @(posedge clk_i) begin
    pay_rd_q <= pay_mem[pay_addr(slot_q, pidx_q)];
    if ((state_q == S_DECIDE) && !cur_q.take && !dup) begin
      pay_mem[pay_addr(slot_q, cur_q.player)] <= cur_q.payload;
    end
  end

  // Result word
  assign res_valid_o = (state_q == S_RESP) || (state_q == S_TAKE);

  always_comb begin
    res_o.out_tick = tick_q;
    if (state_q == S_TAKE) begin
      res_o.status      = tsic_pkg::ST_TAKEN;
      res_o.out_player  = pidx_q;
      res_o.out_payload = pay_rd_q;
      res_o.last        = take_last;
    end else begin
      res_o.status      = status_q;
      res_o.out_player  = cur_q.take ? '0 : cur_q.player;
      res_o.out_payload = '0;
      res_o.last        = 1'b1;
    end
  end

  // Checks
  `TSIC_ASSERT_NXT(a_tick_step, clk_i, rst_ni, 1'b1,
    (next_tick_q == $past(next_tick_q)) || (next_tick_q == $past(next_tick_q) + TICK_W'(1)),
    "next tick moved by more than one")
  `TSIC_ASSERT_IMP(a_slot_range, clk_i, rst_ni, 1'b1,
    32'(next_slot_q) < QUEUE_TICKS, "ring position out of range")
  `TSIC_ASSERT_IMP(a_take_player, clk_i, rst_ni, state_q == S_TAKE,
    ({1'b0, pidx_q} < n_players_i), "take emits an inactive player")
  `TSIC_ASSERT_NXT(a_slot_freed, clk_i, rst_ni,
    (state_q == S_DECIDE) && cur_q.take && take_ok,
    !slot_valid_q[$past(slot_q)], "taken slot not released")

endmodule

[hw/rtl/tick_slot_input_collector_top.sv]
// Top level of the tick slot input collector: config register, front, back, result queue.
// Depends on tsic_pkg, tsic_fifo, tsic_front and tsic_back.
//
//   channel   | handshake          | word
//   ----------+--------------------+-----------------------------
//   input     | push / full        | item_i   (tsic_pkg::in_t)
//   result    | pop / empty        | result_o (tsic_pkg::res_t)
//   config    | cfg_we_i           | cfg_wdata_i (active players)
//
// The front takes one word per cycle, while not full, into a two-entry command queue.
// The back runs one command at a time through idle, check and read. A submit rejected
// for its player or its window then responds; any other submit and a not-ready take
// pass decide first; a complete take passes decide, then fetch and take for each of
// the N active players (one payload store read per result). Reset is asynchronous;
// slot masks clear through per-slot valid flops, so no clearing pass is needed. Each
// side stalls on its own through the command queue and the two-entry result queue.
`timescale 1ns / 1ps

module tick_slot_input_collector_top #(
  parameter int unsigned QUEUE_TICKS  = tsic_pkg::QUEUE_TICKS_DEF,
  parameter int unsigned PLAYER_LIMIT = tsic_pkg::PLAYER_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tsic_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  tsic_pkg::in_t              item_i,
  output logic                       empty,
  input  logic                       pop,
  output tsic_pkg::res_t             result_o
);

  localparam int unsigned CFG_W = tsic_pkg::CFG_W;

  logic [CFG_W-1:0] active_q;
  logic [CFG_W-1:0] n_players;
  logic             q_valid, q_pop;
  tsic_pkg::cmd_t   q_data;
  logic             res_valid, res_full;
  tsic_pkg::res_t   res_word;

  // Active player register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Clamp the player count into 1..PLAYER_LIMIT
  always_comb begin
    if (active_q == '0) begin
      n_players = CFG_W'(1);
    end else if (32'(active_q) > PLAYER_LIMIT) begin
      n_players = CFG_W'(PLAYER_LIMIT);
    end else begin
      n_players = active_q;
    end
  end

  tsic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .n_players_i (n_players),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_data_o    (q_data)
  );

  tsic_back #(
    .QUEUE_TICKS  (QUEUE_TICKS),
    .PLAYER_LIMIT (PLAYER_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_players_i (n_players),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_ready_i (!res_full),
    .res_o       (res_word)
  );

  // Result queue
  tsic_fifo #(
    .WIDTH ($bits(tsic_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .data_i  (res_word),
    .full_o  (res_full),
    .rd_i    (pop),
    .empty_o (empty),
    .data_o  (result_o)
  );

endmodule

[tb/sv/tick_slot_input_collector_checker.sv]
// Scoreboard for the tick slot input collector: predicts each result word from the
// accepted input words and register writes, then compares the result channel in order.
// Depends on tsic_pkg.
`timescale 1ns / 1ps

module tick_slot_input_collector_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsic_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         push_i,
  input  logic                         full_i,
  input  tsic_pkg::in_t                item_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  tsic_pkg::res_t               result_i,
  output int                           mismatch_count_o,
  output int                           owed_count_o,
  output int unsigned                  players_o,
  output logic [tsic_pkg::TICK_W-1:0]  tick_head_o
);

  localparam int unsigned CFG_W            = tsic_pkg::CFG_W;
  localparam int unsigned TICK_W           = tsic_pkg::TICK_W;
  localparam int unsigned PLAYER_W         = tsic_pkg::PLAYER_W;
  localparam int unsigned PAYLOAD_BITS     = tsic_pkg::PAYLOAD_BITS;
  localparam int unsigned PLAYER_LIMIT_DEF = tsic_pkg::PLAYER_LIMIT_DEF;
  localparam int unsigned QUEUE_TICKS_DEF  = tsic_pkg::QUEUE_TICKS_DEF;

  // Predicted block state
  logic [CFG_W-1:0]            player_reg;
  logic [TICK_W-1:0]           tick_head;
  logic [PLAYER_LIMIT_DEF-1:0] slot_mask  [QUEUE_TICKS_DEF];
  logic [PAYLOAD_BITS-1:0]     slot_words [QUEUE_TICKS_DEF][PLAYER_LIMIT_DEF];

  tsic_pkg::res_t owed_results [$];
  tsic_pkg::res_t want_word;
  int             result_index;
  int unsigned    s_idx;
  int unsigned    p_idx;

  assign tick_head_o = tick_head;

  // Register value clamped to 1..PLAYER_LIMIT
  function automatic int unsigned live_players();
    if (player_reg == '0) return 1;
    if (player_reg > PLAYER_LIMIT_DEF) return PLAYER_LIMIT_DEF;
    return int'(player_reg);
  endfunction

  // Apply one input word to the predicted state and queue the words it owes
  function automatic void forecast_results(input tsic_pkg::in_t w);
    int unsigned                 n;
    int unsigned                 slot;
    int unsigned                 p;
    logic [PLAYER_LIMIT_DEF-1:0] all_in;
    tsic_pkg::res_t              r;
    n = live_players();
    r = '0;
    r.last = 1'b1;
    if (w.command == tsic_pkg::CMD_SUBMIT) begin
      r.out_tick   = w.tick_number;
      r.out_player = w.player_id;
      slot = int'(w.tick_number % QUEUE_TICKS_DEF);
      if (w.player_id >= n) begin
        r.status = tsic_pkg::ST_UNKNOWN;
      end else if (w.tick_number < tick_head) begin
        r.status = tsic_pkg::ST_ALREADY;
      end else if (w.tick_number - tick_head >= QUEUE_TICKS_DEF) begin
        r.status = tsic_pkg::ST_AHEAD;
      end else if (slot_mask[slot][w.player_id]) begin
        r.status = tsic_pkg::ST_DUPLICATE;
      end else begin
        slot_words[slot][w.player_id] = w.payload;
        slot_mask[slot][w.player_id]  = 1'b1;
        r.status = tsic_pkg::ST_ACCEPTED;
      end
      owed_results.push_back(r);
    end else begin
      slot = int'(tick_head % QUEUE_TICKS_DEF);
      all_in = '0;
      for (p = 0; p < n; p++) all_in[p] = 1'b1;
      r.out_tick = tick_head;
      if (slot_mask[slot] != all_in) begin
        // stale bits of dropped players also land here
        r.status = tsic_pkg::ST_NOT_READY;
        owed_results.push_back(r);
      end else begin
        for (p = 0; p < n; p++) begin
          r.status      = tsic_pkg::ST_TAKEN;
          r.out_player  = PLAYER_W'(p);
          r.out_payload = slot_words[slot][p];
          r.last        = (p == n - 1);
          owed_results.push_back(r);
        end
        for (p = 0; p < PLAYER_LIMIT_DEF; p++) slot_words[slot][p] = '0;
        slot_mask[slot] = '0;
        tick_head = tick_head + 1'b1;
      end
    end
  endfunction

  task automatic log_mismatch(input string note);
    $display("%0t: result word %0d: %s", $time, result_index, note);
    mismatch_count_o++;
  endtask

  // Compare popped words first, then predict for the pushed word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_reg = CFG_W'(1);
      tick_head  = '0;
      for (s_idx = 0; s_idx < QUEUE_TICKS_DEF; s_idx++) begin
        slot_mask[s_idx] = '0;
        for (p_idx = 0; p_idx < PLAYER_LIMIT_DEF; p_idx++) slot_words[s_idx][p_idx] = '0;
      end
      owed_results.delete();
      result_index     = 0;
      mismatch_count_o = 0;
      owed_count_o     = 0;
      players_o        = live_players();
    end else begin
      if (pop_i && !empty_i) begin
        if (owed_results.size() == 0) begin
          log_mismatch($sformatf("unpredicted word, status %0d tick %0h player %0d",
                                 result_i.status, result_i.out_tick, result_i.out_player));
        end else begin
          want_word = owed_results.pop_front();
          if (result_i.status !== want_word.status)
            log_mismatch($sformatf("status %0d, predicted %0d",
                                   result_i.status, want_word.status));
          if (result_i.out_tick !== want_word.out_tick)
            log_mismatch($sformatf("out_tick %0h, predicted %0h",
                                   result_i.out_tick, want_word.out_tick));
          if (result_i.out_player !== want_word.out_player)
            log_mismatch($sformatf("out_player %0d, predicted %0d",
                                   result_i.out_player, want_word.out_player));
          if (result_i.out_payload !== want_word.out_payload)
            log_mismatch($sformatf("out_payload %0h, predicted %0h",
                                   result_i.out_payload, want_word.out_payload));
          if (result_i.last !== want_word.last)
            log_mismatch($sformatf("last %0b, predicted %0b",
                                   result_i.last, want_word.last));
        end
        result_index++;
      end
      if (cfg_we_i) player_reg = cfg_wdata_i;
      if (push_i && !full_i) forecast_results(item_i);
      owed_count_o = owed_results.size();
      players_o    = live_players();
    end
  end

endmodule

[tb/sv/tick_slot_input_collector_top_tb.sv]
// Testbench top for the tick slot input collector: clock, reset, stimulus and verdict.
// Depends on tsic_pkg, tick_slot_input_collector_top and tick_slot_input_collector_checker.
`timescale 1ns / 1ps

module tick_slot_input_collector_top_tb;

  localparam int unsigned CFG_W            = tsic_pkg::CFG_W;
  localparam int unsigned TICK_W           = tsic_pkg::TICK_W;
  localparam int unsigned PLAYER_W         = tsic_pkg::PLAYER_W;
  localparam int unsigned PAYLOAD_BITS     = tsic_pkg::PAYLOAD_BITS;
  localparam int unsigned PLAYER_LIMIT_DEF = tsic_pkg::PLAYER_LIMIT_DEF;
  localparam int unsigned QUEUE_TICKS_DEF  = tsic_pkg::QUEUE_TICKS_DEF;

  localparam int ITEM_GOAL     = 430;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 24;    // covers a full take with eight players

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             push      = 1'b0;
  logic             full;
  tsic_pkg::in_t    item      = '0;
  logic             empty;
  logic             pop       = 1'b0;
  tsic_pkg::res_t   result;

  int                mismatches;
  int                owed;
  int unsigned       players;
  logic [TICK_W-1:0] tick_head;

  int words_sent    = 0;
  int burst_left    = 1;
  int hold_requests = 0;
  int idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_slot_input_collector_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .item_i      (item),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  tick_slot_input_collector_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .push_i           (push),
    .full_i           (full),
    .item_i           (item),
    .empty_i          (empty),
    .pop_i            (pop),
    .result_i         (result),
    .mismatch_count_o (mismatches),
    .owed_count_o     (owed),
    .players_o        (players),
    .tick_head_o      (tick_head)
  );

  // Watchdog: ends the run when no word moves on either side for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("tick_slot_input_collector_top: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random duty modes, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= $urandom_range(0, 1);
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= (mode_left % 4 != 0);
        endcase
      end
    end
  end

  function automatic tsic_pkg::in_t make_submit(input int unsigned player,
                                                input logic [TICK_W-1:0] tick,
                                                input logic [PAYLOAD_BITS-1:0] word);
    tsic_pkg::in_t w;
    w             = '0;
    w.command     = tsic_pkg::CMD_SUBMIT;
    w.player_id   = PLAYER_W'(player);
    w.tick_number = tick;
    w.payload     = word;
    return w;
  endfunction

  // Take words carry random junk in the fields the block ignores
  function automatic tsic_pkg::in_t make_take();
    tsic_pkg::in_t w;
    w             = '0;
    w.command     = tsic_pkg::CMD_TAKE;
    w.player_id   = $urandom_range(0, 7);
    w.tick_number = {$urandom, $urandom};
    w.payload     = $urandom;
    return w;
  endfunction

  // Off-script word: rejected submits, duplicates, early takes
  function automatic tsic_pkg::in_t stray_word(input logic [TICK_W-1:0] base,
                                               input int unsigned span,
                                               input int unsigned n);
    tsic_pkg::in_t w;
    int unsigned   back;
    w = make_submit($urandom_range(0, n - 1), base + $urandom_range(0, span), $urandom);
    case ($urandom_range(0, 5))
      0: w.player_id = (n < PLAYER_LIMIT_DEF) ? $urandom_range(n, PLAYER_LIMIT_DEF - 1)
                                              : $urandom_range(0, 7);
      1: if (base != '0) begin
           back = (base < 40) ? int'(base) : 40;
           w.tick_number = base - $urandom_range(1, back);
         end
      2: w.tick_number = base + QUEUE_TICKS_DEF + $urandom_range(0, 999);
      3: begin
           w.tick_number = {$urandom, $urandom};
           w.player_id   = $urandom_range(0, 7);
         end
      4: w.player_id = $urandom_range(0, 7);
      default: w = make_take();
    endcase
    return w;
  endfunction

  // Offer one word at a falling edge and hold it until accepted; gaps between bursts
  task automatic send_word(input tsic_pkg::in_t w);
    logic took;
    int   gap;
    item <= w;
    push <= 1'b1;
    do begin
      took = !full;
      @(negedge clk);
    end while (!took);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Register write once the block has drained
  task automatic write_players(input logic [CFG_W-1:0] v);
    push <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Fill one to three ticks with every active player in random order, then take them
  task automatic run_round(input int unsigned n);
    tsic_pkg::in_t     picks [$];
    tsic_pkg::in_t     tmp;
    logic [TICK_W-1:0] base;
    int unsigned       span;
    int unsigned       t;
    int unsigned       p;
    int unsigned       j;
    int unsigned       k;
    int unsigned       tries;
    base = tick_head;
    span = $urandom_range(0, 2);
    for (t = 0; t <= span; t++)
      for (p = 0; p < n; p++) picks.push_back(make_submit(p, base + t, $urandom));
    for (j = picks.size(); j > 1; j--) begin
      k            = $urandom_range(0, j - 1);
      tmp          = picks[j - 1];
      picks[j - 1] = picks[k];
      picks[k]     = tmp;
    end
    foreach (picks[i]) begin
      if ($urandom_range(0, 3) == 0) send_word(stray_word(base, span, n));
      send_word(picks[i]);
    end
    tries = 0;
    while (tick_head != base + span + 1 && tries < span + 4) begin
      send_word(make_take());
      tries++;
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_regs [10];
    int               goal;
    int               p;
    phase_regs = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd1, 4'd9, 4'd2, 4'd7, 4'd6};
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: one player after reset
    send_word(make_submit(0, 0, '0));
    send_word(make_take());
    send_word(make_submit(1, 1, $urandom));        // player beyond the count
    send_word(make_submit(0, 0, $urandom));        // tick already taken
    send_word(make_submit(0, 17, $urandom));       // one past the window
    send_word(make_submit(0, 16, $urandom));       // last tick inside the window
    send_word(make_submit(0, '1, '1));             // top tick, window math wraps
    send_word(make_take());                        // tick 1 empty: not ready
    send_word(make_submit(0, 1, '1));
    send_word(make_submit(0, 1, '0));              // duplicate
    send_word(make_take());

    // Register above the limit acts as eight players
    write_players(4'd15);
    for (p = 8; p > 0; p--) send_word(make_submit(p - 1, 2, $urandom));
    send_word(make_take());

    // Shrink the count with a slot half filled: stale bits block the take
    write_players(4'd4);
    for (p = 0; p < 4; p++) send_word(make_submit(p, 3, $urandom));
    write_players(4'd0);                           // zero acts as one player
    send_word(make_submit(1, 3, $urandom));
    send_word(make_take());
    write_players(4'd4);
    send_word(make_take());

    // Random phases, one register setting each
    foreach (phase_regs[i]) begin
      write_players(phase_regs[i]);
      if (i == 1 || i == 6) hold_requests++;
      goal = words_sent + (ITEM_GOAL - words_sent) / (10 - i);
      while (words_sent < goal) run_round(players);
    end

    push <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tick_slot_input_collector_top: match");
    end else begin
      $display("tick_slot_input_collector_top: mismatch");
    end
    $finish;
  end

endmodule

[tick_slot_input_collector_top.f]
+incdir+hw/rtl
hw/rtl/tsic_pkg.sv
hw/rtl/tsic_fifo.sv
hw/rtl/tsic_front.sv
hw/rtl/tsic_back.sv
hw/rtl/tick_slot_input_collector_top.sv
tb/sv/tick_slot_input_collector_checker.sv
tb/sv/tick_slot_input_collector_top_tb.sv
